/* src/can_frame_filter_rewrite_gateway_macros.svh */
// ----------------------------------------------------------------------------
// CAN gateway assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_FILTER_REWRITE_GATEWAY_MACROS_SVH
`define CAN_FRAME_FILTER_REWRITE_GATEWAY_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CFRG_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define CFRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cfrg_pkg.sv */
// ----------------------------------------------------------------------------
// CAN gateway package
// Item codes, field widths, defaults and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cfrg_pkg;

  // Item codes carried on the slave tuser
  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_LOG_ADD = 2'd1,
    CMD_RW_ADD  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  // Result kinds carried on the master tuser
  localparam logic KIND_LOG = 1'b0;
  localparam logic KIND_FWD = 1'b1;

  localparam logic [7:0] PORT_LOCAL = 8'd1;

  localparam int LOG_SLOTS_DEF     = 3;
  localparam int REWRITE_SLOTS_DEF = 3;
  localparam int TX_FIRST_DEF      = 24;
  localparam int TX_LAST_DEF       = 32;

  localparam int CMD_W   = 2;
  localparam int PORT_W  = 8;
  localparam int MID_W   = 29;
  localparam int KEY_W   = 16;
  localparam int PAY_W   = 64;
  localparam int SLOT_W  = 2;
  localparam int TXO_W   = 6;

  localparam int S_TDATA_W = 200;
  localparam int M_TDATA_W = 104;

  typedef struct packed {
    logic frame_load;
    logic setup_apply;
    logic log_step;
    logic log_end;
    logic rw_step;
    logic fwd_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic log_done;
    logic rw_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* src/can_frame_filter_rewrite_gateway.sv */
// ----------------------------------------------------------------------------
// CAN frame filter and rewrite gateway
// Identifier/mask log filter and payload rewrite for one CAN port.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per transfer; tuser holds the item code
//   (frame, add log entry, add rewrite entry, clear both tables). Set-up items
//   for port 1 append to a table while it has a free slot; other ports and
//   full tables drop the item. Set-up and clear items give no output.
//   A frame gives one log notice per matching log entry, in slot order, then
//   one forward (tlast high) carrying the merged payload and the transmit
//   object, which steps from TX_FIRST to TX_LAST and wraps.
// Timing:
//   The controller stays idle through a set-up item, so the next item can
//   follow it directly. For a frame, one slot per cycle is scanned for each
//   table over its stored entries, the log scan only while the output
//   register is free; the input is held off until the forward is emitted.
//   Results leave through one output register; the next item is taken
//   while the forward still waits.
// Reset and stall:
//   Reset empties both tables, sets the transmit object to TX_FIRST and drops
//   any pending result. A stalled master side holds the log scan and the
//   forward until the output register frees; no result is lost.
// ----------------------------------------------------------------------------
module can_frame_filter_rewrite_gateway #(
  parameter int LOG_SLOTS     = cfrg_pkg::LOG_SLOTS_DEF,
  parameter int REWRITE_SLOTS = cfrg_pkg::REWRITE_SLOTS_DEF,
  parameter int TX_FIRST      = cfrg_pkg::TX_FIRST_DEF,
  parameter int TX_LAST       = cfrg_pkg::TX_LAST_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: target_port[7:0], msg_id[36:8], key_id[52:37], key_mask[68:53],
  //        payload[132:69], payload_mask[196:133], zero[199:197]
  input  logic [cfrg_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  logic [cfrg_pkg::CMD_W-1:0]     s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: log_slot[1:0], frame_id[30:2], frame_data[94:31], tx_object[100:95],
  //        zero[103:101]
  output logic [cfrg_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: kind[0]
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import cfrg_pkg::*;

  cmd_e      cmd;
  dp_cmd_t   ctl;
  dp_stat_t  stat;

  logic [SLOT_W-1:0] log_slot;
  logic [MID_W-1:0]  frame_id;
  logic [PAY_W-1:0]  frame_data;
  logic [TXO_W-1:0]  tx_object;

  assign cmd = cmd_e'(s_axis_tuser_i);

  cfrg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .cmd_i     (cmd),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .ctl_o     (ctl)
  );

  cfrg_datapath #(
    .LOG_SLOTS     (LOG_SLOTS),
    .REWRITE_SLOTS (REWRITE_SLOTS),
    .TX_FIRST      (TX_FIRST),
    .TX_LAST       (TX_LAST)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .port_i         (s_axis_tdata_i[7:0]),
    .msg_id_i       (s_axis_tdata_i[36:8]),
    .key_id_i       (s_axis_tdata_i[52:37]),
    .key_mask_i     (s_axis_tdata_i[68:53]),
    .payload_i      (s_axis_tdata_i[132:69]),
    .payload_mask_i (s_axis_tdata_i[196:133]),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .kind_o         (m_axis_tuser_o),
    .log_slot_o     (log_slot),
    .frame_id_o     (frame_id),
    .frame_data_o   (frame_data),
    .tx_object_o    (tx_object),
    .last_o         (m_axis_tlast_o)
  );

  // Pack the result, first field lowest, zero fill to whole bytes
  assign m_axis_tdata_o = {3'b000, tx_object, frame_data, frame_id, log_slot};

endmodule

/* src/cfrg_ctrl.sv */
// ----------------------------------------------------------------------------
// CAN gateway controller
// Sequences acceptance, log scan, rewrite scan and forward of each frame.
// ----------------------------------------------------------------------------
module cfrg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  cfrg_pkg::cmd_e     cmd_i,
  output logic               s_ready_o,
  input  cfrg_pkg::dp_stat_t stat_i,
  output cfrg_pkg::dp_cmd_t  ctl_o
);
  import cfrg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOG,
    ST_RW,
    ST_FWD
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;
  logic   accept;

  assign accept    = s_valid_i & ready_q;
  assign s_ready_o = ready_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_FRAME) begin
            ctl_o.frame_load = 1'b1;
            state_d          = ST_LOG;
          end else begin
            ctl_o.setup_apply = 1'b1;
          end
        end
      end
      ST_LOG: begin
        if (stat_i.log_done) begin
          ctl_o.log_end = 1'b1;
          state_d       = ST_RW;
        end else if (stat_i.out_free) begin
          ctl_o.log_step = 1'b1;
        end
      end
      ST_RW: begin
        if (stat_i.rw_done) begin
          state_d = ST_FWD;
        end else begin
          ctl_o.rw_step = 1'b1;
        end
      end
      ST_FWD: begin
        if (stat_i.out_free) begin
          ctl_o.fwd_emit = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == ST_IDLE);
    end
  end

endmodule

/* src/cfrg_datapath.sv */
// ----------------------------------------------------------------------------
// CAN gateway datapath
// Entry tables, frame registers, slot scan, merge and the result register.
// ----------------------------------------------------------------------------
`include "can_frame_filter_rewrite_gateway_macros.svh"

module cfrg_datapath #(
  parameter int LOG_SLOTS     = cfrg_pkg::LOG_SLOTS_DEF,
  parameter int REWRITE_SLOTS = cfrg_pkg::REWRITE_SLOTS_DEF,
  parameter int TX_FIRST      = cfrg_pkg::TX_FIRST_DEF,
  parameter int TX_LAST       = cfrg_pkg::TX_LAST_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfrg_pkg::cmd_e               cmd_i,
  input  logic [cfrg_pkg::PORT_W-1:0]  port_i,
  input  logic [cfrg_pkg::MID_W-1:0]   msg_id_i,
  input  logic [cfrg_pkg::KEY_W-1:0]   key_id_i,
  input  logic [cfrg_pkg::KEY_W-1:0]   key_mask_i,
  input  logic [cfrg_pkg::PAY_W-1:0]   payload_i,
  input  logic [cfrg_pkg::PAY_W-1:0]   payload_mask_i,
  input  cfrg_pkg::dp_cmd_t            ctl_i,
  output cfrg_pkg::dp_stat_t           stat_o,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic                         kind_o,
  output logic [cfrg_pkg::SLOT_W-1:0]  log_slot_o,
  output logic [cfrg_pkg::MID_W-1:0]   frame_id_o,
  output logic [cfrg_pkg::PAY_W-1:0]   frame_data_o,
  output logic [cfrg_pkg::TXO_W-1:0]   tx_object_o,
  output logic                         last_o
);
  import cfrg_pkg::*;

  localparam int MaxSlots = (LOG_SLOTS > REWRITE_SLOTS) ? LOG_SLOTS : REWRITE_SLOTS;
  localparam int CNT_W    = $clog2(MaxSlots + 1);
  localparam int LIDX_W   = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
  localparam int RIDX_W   = (REWRITE_SLOTS > 1) ? $clog2(REWRITE_SLOTS) : 1;
  localparam int TxMax    = (TX_FIRST > TX_LAST) ? TX_FIRST : TX_LAST;

  localparam logic [CNT_W-1:0] LogFull = CNT_W'(LOG_SLOTS);
  localparam logic [CNT_W-1:0] RwFull  = CNT_W'(REWRITE_SLOTS);
  localparam logic [TXO_W-1:0] TxFirst = TXO_W'(TX_FIRST);
  localparam logic [TXO_W-1:0] TxLast  = TXO_W'(TX_LAST);

  // Entry tables, read at the scan index only
  logic [KEY_W-1:0] log_id_q    [LOG_SLOTS];
  logic [KEY_W-1:0] log_mask_q  [LOG_SLOTS];
  logic [KEY_W-1:0] rw_id_q     [REWRITE_SLOTS];
  logic [KEY_W-1:0] rw_mask_q   [REWRITE_SLOTS];
  logic [PAY_W-1:0] rw_bytes_q  [REWRITE_SLOTS];
  logic [PAY_W-1:0] rw_bmask_q  [REWRITE_SLOTS];

  logic [CNT_W-1:0] log_cnt_q, rw_cnt_q, idx_q;
  logic [TXO_W-1:0] tx_q, tx_inc;

  logic [MID_W-1:0] mid_q;
  logic [PAY_W-1:0] orig_q, data_q;

  logic             m_valid_q;
  logic             kind_q, last_q;
  logic [SLOT_W-1:0] slot_q;
  logic [MID_W-1:0] fid_q;
  logic [PAY_W-1:0] fdata_q;
  logic [TXO_W-1:0] txo_q;

  logic [LIDX_W-1:0] lidx;
  logic [RIDX_W-1:0] ridx;
  logic              log_hit, rw_hit, log_add, rw_add, notice_load;

  assign lidx = idx_q[LIDX_W-1:0];
  assign ridx = idx_q[RIDX_W-1:0];

  // Only the low identifier bits are compared, masks being 16 bits wide
  assign log_hit = ((mid_q[KEY_W-1:0] ^ log_id_q[lidx]) & log_mask_q[lidx]) == '0;
  assign rw_hit  = ((mid_q[KEY_W-1:0] ^ rw_id_q[ridx]) & rw_mask_q[ridx]) == '0;

  assign log_add = ctl_i.setup_apply && (cmd_i == CMD_LOG_ADD) &&
                   (port_i == PORT_LOCAL) && (log_cnt_q < LogFull);
  assign rw_add  = ctl_i.setup_apply && (cmd_i == CMD_RW_ADD) &&
                   (port_i == PORT_LOCAL) && (rw_cnt_q < RwFull);

  assign notice_load = ctl_i.log_step && log_hit;

  assign tx_inc = tx_q + TXO_W'(1);

  assign stat_o.log_done = (idx_q >= log_cnt_q);
  assign stat_o.rw_done  = (idx_q >= rw_cnt_q);
  assign stat_o.out_free = !m_valid_q || m_ready_i;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_cnt_q <= '0;
      rw_cnt_q  <= '0;
      idx_q     <= '0;
      tx_q      <= TxFirst;
      m_valid_q <= 1'b0;
    end else begin
      if (ctl_i.setup_apply && (cmd_i == CMD_CLEAR)) begin
        log_cnt_q <= '0;
        rw_cnt_q  <= '0;
      end
      if (log_add) begin
        log_cnt_q <= log_cnt_q + CNT_W'(1);
      end
      if (rw_add) begin
        rw_cnt_q <= rw_cnt_q + CNT_W'(1);
      end
      if (ctl_i.frame_load || ctl_i.log_end) begin
        idx_q <= '0;
      end else if (ctl_i.log_step || ctl_i.rw_step) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (ctl_i.fwd_emit) begin
        tx_q <= (tx_inc > TxLast) ? TxFirst : tx_inc;
      end
      if (notice_load || ctl_i.fwd_emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Tables, frame and result payload
  always_ff @(posedge clk_i) begin
    if (log_add) begin
      log_id_q[log_cnt_q[LIDX_W-1:0]]   <= key_id_i;
      log_mask_q[log_cnt_q[LIDX_W-1:0]] <= key_mask_i;
    end
    if (rw_add) begin
      rw_id_q[rw_cnt_q[RIDX_W-1:0]]    <= key_id_i;
      rw_mask_q[rw_cnt_q[RIDX_W-1:0]]  <= key_mask_i;
      rw_bytes_q[rw_cnt_q[RIDX_W-1:0]] <= payload_i;
      rw_bmask_q[rw_cnt_q[RIDX_W-1:0]] <= payload_mask_i;
    end
    if (ctl_i.frame_load) begin
      mid_q  <= msg_id_i;
      orig_q <= payload_i;
      data_q <= payload_i;
    end else if (ctl_i.rw_step && rw_hit) begin
      data_q <= (data_q & ~rw_bmask_q[ridx]) | (rw_bytes_q[ridx] & rw_bmask_q[ridx]);
    end
    if (notice_load) begin
      kind_q  <= KIND_LOG;
      slot_q  <= SLOT_W'(idx_q);
      fid_q   <= MID_W'(log_id_q[lidx]);
      fdata_q <= orig_q;
      txo_q   <= '0;
      last_q  <= 1'b0;
    end else if (ctl_i.fwd_emit) begin
      kind_q  <= KIND_FWD;
      slot_q  <= '0;
      fid_q   <= mid_q;
      fdata_q <= data_q;
      txo_q   <= tx_q;
      last_q  <= 1'b1;
    end
  end

  assign m_valid_o    = m_valid_q;
  assign kind_o       = kind_q;
  assign log_slot_o   = slot_q;
  assign frame_id_o   = fid_q;
  assign frame_data_o = fdata_q;
  assign tx_object_o  = txo_q;
  assign last_o       = last_q;

  `CFRG_ASSERT(a_log_cnt_bound, log_cnt_q <= LogFull, "log count above slot count")
  `CFRG_ASSERT(a_rw_cnt_bound, rw_cnt_q <= RwFull, "rewrite count above slot count")
  `CFRG_ASSERT(a_tx_bound, tx_q <= TXO_W'(TxMax), "transmit object out of range")
  `CFRG_ASSERT_NEXT(a_notice_out, notice_load, m_valid_q && (kind_q == KIND_LOG) && !last_q, "log notice not presented")
  `CFRG_ASSERT_NEXT(a_fwd_out, ctl_i.fwd_emit, m_valid_q && (kind_q == KIND_FWD) && last_q, "forward not presented")

endmodule

/* tb/can_frame_filter_rewrite_gateway_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN frame filter and rewrite gateway testbench
// Drives set-up, clear and frame transfers into the slave stream and checks
// every log notice and forward on the master stream. The expected results
// come from a local copy of both tables and the transmit object. Both sides
// idle at random, and one phase holds the master side off for a long
// stretch so that the gateway fills up and stalls its input.
// ----------------------------------------------------------------------------
module can_frame_filter_rewrite_gateway_tb;
  import cfrg_pkg::*;

  localparam int MAX_GAP     = 17;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [MID_W-1:0]  fid;
    logic [PAY_W-1:0]  data;
    logic [TXO_W-1:0]  txo;
    logic              last;
  } gw_result_t;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [CMD_W-1:0]     s_axis_tuser_i  = CMD_FRAME;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // Local copy of the gateway state
  logic [KEY_W-1:0] log_key_tbl [LOG_SLOTS_DEF];
  logic [KEY_W-1:0] log_msk_tbl [LOG_SLOTS_DEF];
  int               log_cnt;
  logic [KEY_W-1:0] rw_key_tbl  [REWRITE_SLOTS_DEF];
  logic [KEY_W-1:0] rw_msk_tbl  [REWRITE_SLOTS_DEF];
  logic [PAY_W-1:0] rw_val_tbl  [REWRITE_SLOTS_DEF];
  logic [PAY_W-1:0] rw_sel_tbl  [REWRITE_SLOTS_DEF];
  int               rw_cnt;
  logic [TXO_W-1:0] next_tx_obj;

  gw_result_t notice_fwd_q [$];
  int         mismatch_cnt;
  int         cycle_cnt;
  bit         idle_on       = 1'b1;
  bit         sink_hold_req = 1'b0;

  can_frame_filter_rewrite_gateway u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run guard: end the run if the traffic never drains
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("RESULT: ERROR");
    $finish;
  end

  // Apply one accepted item to the local state and queue the results it
  // causes: one notice per matching log entry, then the merged forward.
  function automatic void gateway_apply(cmd_e cmd, logic [PORT_W-1:0] port,
                                        logic [MID_W-1:0] mid, logic [KEY_W-1:0] kid,
                                        logic [KEY_W-1:0] kmask, logic [PAY_W-1:0] pay,
                                        logic [PAY_W-1:0] pmask);
    gw_result_t       res;
    logic [PAY_W-1:0] merged;
    case (cmd)
      CMD_LOG_ADD: begin
        if (port == PORT_LOCAL && log_cnt < LOG_SLOTS_DEF) begin
          log_key_tbl[log_cnt] = kid;
          log_msk_tbl[log_cnt] = kmask;
          log_cnt++;
        end
      end
      CMD_RW_ADD: begin
        if (port == PORT_LOCAL && rw_cnt < REWRITE_SLOTS_DEF) begin
          rw_key_tbl[rw_cnt] = kid;
          rw_msk_tbl[rw_cnt] = kmask;
          rw_val_tbl[rw_cnt] = pay;
          rw_sel_tbl[rw_cnt] = pmask;
          rw_cnt++;
        end
      end
      CMD_CLEAR: begin
        // Only the counts drop; stale entries stay behind unread
        log_cnt = 0;
        rw_cnt  = 0;
      end
      default: begin
        // Only the low 16 identifier bits ever take part in a match
        for (int i = 0; i < log_cnt; i++) begin
          if ((mid[KEY_W-1:0] & log_msk_tbl[i]) == (log_key_tbl[i] & log_msk_tbl[i])) begin
            res.kind = KIND_LOG;
            res.slot = SLOT_W'(i);
            res.fid  = MID_W'(log_key_tbl[i]);
            res.data = pay;
            res.txo  = '0;
            res.last = 1'b0;
            notice_fwd_q.push_back(res);
          end
        end
        merged = pay;
        for (int i = 0; i < rw_cnt; i++) begin
          if ((mid[KEY_W-1:0] & rw_msk_tbl[i]) == (rw_key_tbl[i] & rw_msk_tbl[i]))
            merged = (merged & ~rw_sel_tbl[i]) | (rw_val_tbl[i] & rw_sel_tbl[i]);
        end
        res.kind = KIND_FWD;
        res.slot = '0;
        res.fid  = mid;
        res.data = merged;
        res.txo  = next_tx_obj;
        res.last = 1'b1;
        notice_fwd_q.push_back(res);
        next_tx_obj = next_tx_obj + 1'b1;
        if (next_tx_obj > TX_LAST_DEF)
          next_tx_obj = TX_FIRST_DEF;
      end
    endcase
  endfunction

  // Offer one item, hold it until the transfer, then idle for a random gap.
  // Valid stays high across a zero gap so it is never dropped and raised in
  // the same step.
  task automatic send_item(cmd_e cmd, logic [PORT_W-1:0] port, logic [MID_W-1:0] mid,
                           logic [KEY_W-1:0] kid, logic [KEY_W-1:0] kmask,
                           logic [PAY_W-1:0] pay, logic [PAY_W-1:0] pmask);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {3'b000, pmask, pay, kmask, kid, mid, port};
    do @(posedge clk_i); while (!s_axis_tready_o);
    gateway_apply(cmd, port, mid, kid, kmask, pay, pmask);
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [PAY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_frame(logic [MID_W-1:0] mid, logic [PAY_W-1:0] pay);
    send_item(CMD_FRAME, PORT_W'($urandom), mid, KEY_W'($urandom), KEY_W'($urandom),
              pay, rand_word());
  endtask

  task automatic send_log(logic [PORT_W-1:0] port, logic [KEY_W-1:0] kid,
                          logic [KEY_W-1:0] kmask);
    send_item(CMD_LOG_ADD, port, MID_W'($urandom), kid, kmask, rand_word(), rand_word());
  endtask

  task automatic send_rewrite(logic [PORT_W-1:0] port, logic [KEY_W-1:0] kid,
                              logic [KEY_W-1:0] kmask, logic [PAY_W-1:0] pay,
                              logic [PAY_W-1:0] pmask);
    send_item(CMD_RW_ADD, port, MID_W'($urandom), kid, kmask, pay, pmask);
  endtask

  task automatic send_clear(logic [PORT_W-1:0] port);
    send_item(CMD_CLEAR, port, MID_W'($urandom), KEY_W'($urandom), KEY_W'($urandom),
              rand_word(), rand_word());
  endtask

  function automatic logic [KEY_W-1:0] rand_key_mask();
    case ($urandom_range(0, 4))
      0: return '1;
      1: return '0;
      2: return 16'hFFFF << $urandom_range(0, 15);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  function automatic logic [PAY_W-1:0] rand_byte_mask();
    logic [PAY_W-1:0] sel;
    case ($urandom_range(0, 3))
      0: sel = '1;
      1: sel = rand_word();
      default: begin
        for (int b = 0; b < 8; b++)
          sel[8*b +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    endcase
    return sel;
  endfunction

  // Steer most frames onto a stored key so the tables actually hit
  function automatic logic [MID_W-1:0] pick_frame_id();
    logic [MID_W-1:0] mid;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] msk;
    int               j;
    mid = MID_W'($urandom);
    if ($urandom_range(0, 9) < 7 && (log_cnt + rw_cnt) > 0) begin
      j = $urandom_range(0, log_cnt + rw_cnt - 1);
      if (j < log_cnt) begin
        key = log_key_tbl[j];
        msk = log_msk_tbl[j];
      end else begin
        key = rw_key_tbl[j - log_cnt];
        msk = rw_msk_tbl[j - log_cnt];
      end
      mid[KEY_W-1:0] = (key & msk) | (mid[KEY_W-1:0] & ~msk);
    end
    return mid;
  endfunction

  // Master side: stall a random number of cycles before each transfer, and
  // once hold off for a long stretch when asked to.
  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  task automatic check_field(string name, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    gw_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (notice_fwd_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d id %h data %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o[30:2], m_axis_tdata_o[94:31]);
        mismatch_cnt++;
      end else begin
        want = notice_fwd_q.pop_front();
        check_field("kind",       want.kind, m_axis_tuser_o);
        check_field("log_slot",   want.slot, m_axis_tdata_o[1:0]);
        check_field("frame_id",   want.fid,  m_axis_tdata_o[30:2]);
        check_field("frame_data", want.data, m_axis_tdata_o[94:31]);
        check_field("tx_object",  want.txo,  m_axis_tdata_o[100:95]);
        check_field("last",       want.last, m_axis_tlast_o);
      end
    end
  end

  // Extremes, ignored set-up, full tables, identifier width and clear
  task automatic test_directed();
    send_frame('0, '0);
    send_frame('1, '1);
    send_log(8'd0, 16'h1234, 16'hFFFF);
    send_rewrite(8'd255, 16'h1234, 16'hFFFF, '1, '1);
    send_log(PORT_LOCAL, 16'h1234, 16'hFFFF);
    send_log(PORT_LOCAL, 16'h0000, 16'h0000);
    send_log(PORT_LOCAL, 16'hFFFF, 16'hFF00);
    send_log(PORT_LOCAL, 16'h5555, 16'hFFFF);
    send_rewrite(PORT_LOCAL, 16'h1234, 16'hFFFF, 64'hA5A5_5A5A_C3C3_3C3C,
                 64'h0000_0000_FFFF_FFFF);
    send_rewrite(PORT_LOCAL, 16'h0000, 16'h0000, '1, 64'hFF00_FF00_FF00_FF00);
    send_rewrite(PORT_LOCAL, 16'hFFFF, 16'hFFFF, '0, '1);
    send_rewrite(PORT_LOCAL, 16'h1234, 16'h0000, '1, '1);
    send_frame(29'h0000_1234, rand_word());
    send_frame({13'h1FFF, 16'h1234}, rand_word());
    send_frame(29'h0000_FFFF, '1);
    send_frame(29'h1FFF_FF00, '0);
    send_clear(8'hAA);
    send_frame(29'h0000_1234, rand_word());
    send_log(PORT_LOCAL, 16'h00FF, 16'h00FF);
    send_frame(29'h0000_12FF, rand_word());
    send_clear(PORT_LOCAL);
  endtask

  // Stall the master side for a long stretch while frames keep coming
  task automatic test_output_backpressure();
    idle_on       = 1'b0;
    sink_hold_req = 1'b1;
    send_clear(PORT_LOCAL);
    for (int i = 0; i < LOG_SLOTS_DEF; i++)
      send_log(PORT_LOCAL, KEY_W'($urandom), 16'h0000);
    for (int i = 0; i < REWRITE_SLOTS_DEF; i++)
      send_rewrite(PORT_LOCAL, KEY_W'($urandom), rand_key_mask(), rand_word(),
                   rand_byte_mask());
    repeat (25) send_frame(pick_frame_id(), rand_word());
    idle_on = 1'b1;
  endtask

  // Mostly well-formed table fills followed by frames, with noise set-up
  // for other ports and appends to full tables mixed in
  task automatic test_random_traffic(int n_items);
    int               taken;
    int               steps;
    int               pick;
    logic [PORT_W-1:0] port;
    taken = 0;
    steps = 0;
    while (taken < n_items) begin
      if (steps % 40 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      steps++;
      pick = $urandom_range(0, 99);
      port = ($urandom_range(0, 9) == 0) ? PORT_W'($urandom) : PORT_LOCAL;
      if (pick < 5) begin
        send_clear(PORT_W'($urandom));
        taken++;
      end else if (pick < 17) begin
        if (port == PORT_LOCAL && log_cnt < LOG_SLOTS_DEF)
          taken++;
        send_log(port, KEY_W'($urandom), rand_key_mask());
      end else if (pick < 29) begin
        if (port == PORT_LOCAL && rw_cnt < REWRITE_SLOTS_DEF)
          taken++;
        send_rewrite(port, KEY_W'($urandom), rand_key_mask(), rand_word(),
                     rand_byte_mask());
      end else begin
        send_frame(pick_frame_id(), rand_word());
        taken++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin : main_seq
    log_cnt      = 0;
    rw_cnt       = 0;
    next_tx_obj  = TX_FIRST_DEF;
    mismatch_cnt = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_output_backpressure();
    test_random_traffic(260);

    // Drain: release the input, wait out every expected result, then linger
    s_axis_tvalid_i <= 1'b0;
    while (notice_fwd_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
